/* hdl/frame_time_average_fps_meter_assert.svh */
// ---------------------------------------------------------------------------
// frame time meter assertion macros
// concurrent checks clocked on i_clk and held off while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef FRAME_TIME_AVERAGE_FPS_METER_ASSERT_SVH
`define FRAME_TIME_AVERAGE_FPS_METER_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold at every edge out of reset
`define FPSM_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("fpsm check failed");

// antecedent at one edge implies consequent at the next edge
`define FPSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fpsm sequence check failed");

`else

`define FPSM_ASSERT_ALWAYS(lbl, cond)
`define FPSM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hdl/fpsm_pkg.sv */
// ---------------------------------------------------------------------------
// fpsm_pkg
// shared widths, types and codes of the frame time meter
// ---------------------------------------------------------------------------
package fpsm_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int DATA_W       = 16;
    localparam int TOTAL_W      = 40;
    localparam int ACC_W        = DATA_W + 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int SUM_W        = DATA_W + $clog2(WINDOW_DEPTH);
    localparam int DCNT_W       = $clog2(SUM_W + 1);

    localparam logic [DATA_W-1:0] OUTLIER_RESET = 16'd1000;
    localparam logic [DATA_W-1:0] PERIOD_RESET  = 16'd1000;

    localparam logic CFG_OUTLIER = 1'b0;
    localparam logic CFG_PERIOD  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* hdl/fpsm_cell.sv */
// ---------------------------------------------------------------------------
// fpsm_cell
// one entry of the frame window chain, loads its neighbor value when enabled
// ---------------------------------------------------------------------------
module fpsm_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [fpsm_pkg::DATA_W-1:0] i_d,
    output logic [fpsm_pkg::DATA_W-1:0] o_q
);
    import fpsm_pkg::*;

    logic [DATA_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_en) begin
            r_val <= i_d;
        end
    end

    assign o_q = r_val;

endmodule

/* hdl/fpsm_div.sv */
// ---------------------------------------------------------------------------
// fpsm_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module fpsm_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpsm_pkg::t_div_req   i_req,
    output fpsm_pkg::t_div_rsp   o_rsp
);
    import fpsm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [SUM_W-1:0]  r_quo;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        ge    = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DCNT_W'(1);
                if (r_cnt == DCNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* hdl/frame_time_average_fps_meter.sv */
// ---------------------------------------------------------------------------
// frame_time_average_fps_meter
// frame time moving average, frame rate and play time meter
// ---------------------------------------------------------------------------
// From accept to result an item goes through these steps: the accept cycle
// updates the counters and shifts the frame into the window unless it is an
// outlier, the window chain then rotates once around (one cell per cycle)
// while its tail is summed, and the serial divider produces one quotient bit
// per cycle of the sum. A restart item clears the average and the played
// time and goes straight to the result. The next item is taken as soon as
// the result sits in the output register, even if it is not yet taken.
module frame_time_average_fps_meter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [fpsm_pkg::DATA_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [fpsm_pkg::DATA_W-1:0]  i_frame_time_ms,
    input  logic                         i_restart,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [fpsm_pkg::DATA_W-1:0]  o_average_frame_ms,
    output logic [fpsm_pkg::DATA_W-1:0]  o_frames_per_period,
    output logic [fpsm_pkg::TOTAL_W-1:0] o_total_played_ms
);
    import fpsm_pkg::*;

`include "frame_time_average_fps_meter_assert.svh"

    t_state             r_state;
    logic [DATA_W-1:0]  r_outlier;
    logic [DATA_W-1:0]  r_period;
    logic [CNT_W-1:0]   r_cnt;
    logic [DATA_W-1:0]  r_avg;
    logic [DATA_W-1:0]  r_fc;
    logic [ACC_W-1:0]   r_acc;
    logic [DATA_W-1:0]  r_rate;
    logic [TOTAL_W-1:0] r_played;
    logic [SUM_W-1:0]   r_sum;
    logic [IDX_W-1:0]   r_idx;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_o_avg;
    logic [DATA_W-1:0]  r_o_rate;
    logic [TOTAL_W-1:0] r_o_played;

    logic               in_acc;
    logic               out_load;
    logic [DATA_W-1:0]  diff_ms;
    logic               store;
    logic [DATA_W-1:0]  fc_inc;
    logic [ACC_W-1:0]   acc_add;
    logic [SUM_W-1:0]   sum_next;
    logic               last_rot;
    logic [DATA_W-1:0]  avg_new;

    logic [DATA_W-1:0]  cell_q [WINDOW_DEPTH];
    logic [DATA_W-1:0]  head_d;
    logic               chain_en;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    // result register frees up, or is already free
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        diff_ms  = (i_frame_time_ms >= r_avg) ? (i_frame_time_ms - r_avg)
                                              : (r_avg - i_frame_time_ms);
        store    = in_acc & ~i_restart & (diff_ms < r_outlier);
        fc_inc   = (r_fc != {DATA_W{1'b1}}) ? (r_fc + DATA_W'(1)) : r_fc;
        acc_add  = r_acc + ACC_W'(i_frame_time_ms);
        sum_next = r_sum + SUM_W'(cell_q[WINDOW_DEPTH-1]);
        last_rot = (r_state == S_SUM) && (r_idx == IDX_W'(WINDOW_DEPTH - 1));
        // average is zero with an empty window; quotient saturates at the field width
        if (r_cnt == '0) begin
            avg_new = '0;
        end else if (|div_rsp.quotient[SUM_W-1:DATA_W]) begin
            avg_new = {DATA_W{1'b1}};
        end else begin
            avg_new = div_rsp.quotient[DATA_W-1:0];
        end
    end

    // window chain: shift in a stored frame, or rotate once around to sum it
    assign chain_en = store | (r_state == S_SUM);
    assign head_d   = (r_state == S_SUM) ? cell_q[WINDOW_DEPTH-1] : i_frame_time_ms;

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        fpsm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (chain_en),
            .i_d     ((g == 0) ? head_d : cell_q[(g == 0) ? 0 : g - 1]),
            .o_q     (cell_q[g])
        );
    end

    assign div_req.start    = last_rot;
    assign div_req.dividend = sum_next;
    assign div_req.divisor  = r_cnt;

    fpsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outlier <= OUTLIER_RESET;
            r_period  <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OUTLIER: r_outlier <= i_cfg_data;
                CFG_PERIOD:  r_period  <= i_cfg_data;
                default:     r_period  <= r_period;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_avg       <= '0;
            r_fc        <= '0;
            r_acc       <= '0;
            r_rate      <= '0;
            r_played    <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_restart) begin
                            r_avg    <= '0;
                            r_played <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            if (store && (r_cnt != CNT_W'(WINDOW_DEPTH))) begin
                                r_cnt <= r_cnt + CNT_W'(1);
                            end
                            if ({1'b0, r_period} < acc_add) begin
                                r_rate <= fc_inc;
                                r_fc   <= '0;
                                r_acc  <= '0;
                            end else begin
                                r_fc  <= fc_inc;
                                r_acc <= acc_add;
                            end
                            r_played <= r_played + TOTAL_W'(i_frame_time_ms);
                            r_idx    <= '0;
                            r_state  <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (last_rot) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_avg   <= avg_new;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_sum <= '0;
        end else if (r_state == S_SUM) begin
            r_sum <= sum_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_avg    <= r_avg;
            r_o_rate   <= r_rate;
            r_o_played <= r_played;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_average_frame_ms  = r_o_avg;
    assign o_frames_per_period = r_o_rate;
    assign o_total_played_ms   = r_o_played;

    `FPSM_ASSERT_ALWAYS(a_cnt_max, r_cnt <= CNT_W'(WINDOW_DEPTH))
    `FPSM_ASSERT_ALWAYS(a_div_done_state, !div_rsp.done || (r_state == S_DIV))
    `FPSM_ASSERT_NEXT(a_item_to_sum, in_acc && !i_restart, r_state == S_SUM)

endmodule
